// ----- sv/bta_pkg.sv -----
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types and constants of the boundary tag heap allocator.
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int HEAP_DEPTH = 4096;
  localparam int ADDR_W     = 12;
  localparam int WORD_W     = 16;
  localparam int CFG_W      = 13;
  localparam int SCAN_FITS  = 20;
  localparam int MIN_BLOCK  = 4;
  localparam int TAG_WORDS  = 2;
  localparam int ALU_W      = 18;

  localparam logic [1:0] ACT_FORMAT  = 2'd0;
  localparam logic [1:0] ACT_ALLOC   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  localparam logic [2:0] ST_ALLOC   = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_NOFIT   = 3'd2;
  localparam logic [2:0] ST_FREED   = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;
  localparam logic [2:0] ST_FORMAT  = 3'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [14:0] request_bytes;
    logic [11:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [11:0] handle_res;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

endpackage

// ----- sv/boundary_tag_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// Boundary tag heap with best fit among the first twenty fitting free blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Command beat: in_data is taken when start is high and busy is low.
//   action format lays out the heap over cfg_wdata words (clamped 8..4096),
//   allocate returns a handle, release merges the block with free neighbours.
//   Each command gives exactly one result beat: out_valid high for one cycle
//   with out_data; the receiver cannot stall, so it must take it then.
//   Every store access goes through one write port and one registered read
//   port, so allocate visits the free blocks one at a time (at most 20 fits,
//   list walk bounded). An undefined action is answered while busy stays low.
//   busy stays high until the result beat, and the next command may start
//   in that same cycle.
//   cfg_we writes the heap size register, only while idle: a user rule, not enforced.
//   Reset (synchronous, rst_n low) empties the free list and clears the
//   formatted flag; the store itself holds nothing meaningful until format.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  bta_pkg::in_item_t             in_data,
  output logic                          out_valid,
  output bta_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [bta_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_F0    = 6'd1;
  localparam logic [5:0] S_F1    = 6'd2;
  localparam logic [5:0] S_F2    = 6'd3;
  localparam logic [5:0] S_F3    = 6'd4;
  localparam logic [5:0] S_AINI  = 6'd5;
  localparam logic [5:0] S_ACHK  = 6'd6;
  localparam logic [5:0] S_ASZ   = 6'd7;
  localparam logic [5:0] S_ANX   = 6'd8;
  localparam logic [5:0] S_ADONE = 6'd9;
  localparam logic [5:0] S_ASPL  = 6'd10;
  localparam logic [5:0] S_AT2   = 6'd11;
  localparam logic [5:0] S_AFIN  = 6'd12;
  localparam logic [5:0] S_RCHK  = 6'd13;
  localparam logic [5:0] S_RHD   = 6'd14;
  localparam logic [5:0] S_RLB   = 6'd15;
  localparam logic [5:0] S_RLW   = 6'd16;
  localparam logic [5:0] S_RLS   = 6'd17;
  localparam logic [5:0] S_RLA   = 6'd18;
  localparam logic [5:0] S_RRC   = 6'd19;
  localparam logic [5:0] S_RRW   = 6'd20;
  localparam logic [5:0] S_RRS   = 6'd21;
  localparam logic [5:0] S_RRA   = 6'd22;
  localparam logic [5:0] S_RMF   = 6'd23;
  localparam logic [5:0] S_RFIN  = 6'd24;
  localparam logic [5:0] S_U0    = 6'd25;
  localparam logic [5:0] S_U1    = 6'd26;
  localparam logic [5:0] S_U2    = 6'd27;
  localparam logic [5:0] S_U3    = 6'd28;
  localparam logic [5:0] S_M0    = 6'd29;
  localparam logic [5:0] S_M1    = 6'd30;
  localparam logic [5:0] S_M2    = 6'd31;
  localparam logic [5:0] S_M3    = 6'd32;
  localparam logic [5:0] S_M4    = 6'd33;

  localparam int AW = bta_pkg::ADDR_W;
  localparam int WW = bta_pkg::WORD_W;
  localparam int SW = WW + 1;
  localparam int BW = bta_pkg::ALU_W;

  logic [5:0]                 state_r, state_nxt, ret_r, ret_nxt;
  bta_pkg::in_item_t          item_r, item_nxt;
  bta_pkg::out_item_t         out_r, out_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [bta_pkg::CFG_W-1:0]  cfg_r, heap_len_r, heap_len_nxt;
  logic                       formatted_r, formatted_nxt;
  logic [AW-1:0]              fh_r, fh_nxt;
  logic [AW-1:0]              p_r, p_nxt, pick_r, pick_nxt, at_r, at_nxt;
  logic [AW-1:0]              lft_r, lft_nxt, rgt_r, rgt_nxt, u_r, u_nxt;
  logic [AW-1:0]              pv_r, pv_nxt, nx_r, nx_nxt, mi_r, mi_nxt;
  logic [WW-1:0]              mw_r, mw_nxt;
  logic [SW-1:0]              sz_r, sz_nxt, need_r, need_nxt, tw_r, tw_nxt;
  logic [BW-1:0]              best_r, best_nxt;
  logic                       split_r, split_nxt;
  logic [AW:0]                steps_r, steps_nxt;
  logic [4:0]                 left_r, left_nxt;

  bta_pkg::mem_wr_t           wr;
  logic [AW-1:0]              raddr;
  logic [WW-1:0]              rdata;
  logic [SW-1:0]              rabs;
  bta_pkg::alu_req_t          alu_req;
  logic [BW-1:0]              alu_sum;
  logic [bta_pkg::CFG_W-1:0]  len_c;
  logic [13:0]                words_c;
  logic [SW-1:0]              need_c;

  bta_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  bta_alu u_alu (
    .req (alu_req),
    .sum (alu_sum)
  );

  assign rabs = rdata[WW-1] ? {1'b0, ~rdata} + SW'(1) : {1'b0, rdata};

  always_comb begin
    if (cfg_r < bta_pkg::CFG_W'(8)) begin
      len_c = bta_pkg::CFG_W'(8);
    end else if (cfg_r > bta_pkg::CFG_W'(bta_pkg::HEAP_DEPTH)) begin
      len_c = bta_pkg::CFG_W'(bta_pkg::HEAP_DEPTH);
    end else begin
      len_c = cfg_r;
    end
  end

  assign words_c = 14'((16'(item_r.request_bytes) + 16'd3) >> 2);
  always_comb begin
    need_c = SW'(words_c) + SW'(bta_pkg::TAG_WORDS);
    if (need_c < SW'(bta_pkg::MIN_BLOCK)) begin
      need_c = SW'(bta_pkg::MIN_BLOCK);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    item_nxt      = item_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    heap_len_nxt  = heap_len_r;
    formatted_nxt = formatted_r;
    fh_nxt        = fh_r;
    p_nxt         = p_r;
    pick_nxt      = pick_r;
    at_nxt        = at_r;
    lft_nxt       = lft_r;
    rgt_nxt       = rgt_r;
    u_nxt         = u_r;
    pv_nxt        = pv_r;
    nx_nxt        = nx_r;
    mi_nxt        = mi_r;
    mw_nxt        = mw_r;
    sz_nxt        = sz_r;
    need_nxt      = need_r;
    tw_nxt        = tw_r;
    best_nxt      = best_r;
    split_nxt     = split_r;
    steps_nxt     = steps_r;
    left_nxt      = left_r;
    wr            = '0;
    raddr         = '0;
    alu_req       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt = in_data;
          unique case (in_data.action)
            bta_pkg::ACT_FORMAT:  state_nxt = S_F0;
            bta_pkg::ACT_ALLOC:   state_nxt = S_AINI;
            bta_pkg::ACT_RELEASE: state_nxt = S_RCHK;
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{handle_res: '0, status: bta_pkg::ST_IGNORED};
            end
          endcase
        end
      end
      // format
      S_F0: begin
        fh_nxt = '0;
        wr     = '{we: 1'b1, addr: AW'(0), data: -WW'(bta_pkg::TAG_WORDS)};
        state_nxt = S_F1;
      end
      S_F1: begin
        wr     = '{we: 1'b1, addr: AW'(1), data: -WW'(bta_pkg::TAG_WORDS)};
        mi_nxt = AW'(2);
        mw_nxt = WW'(len_c) - WW'(4);
        ret_nxt   = S_F2;
        state_nxt = S_M0;
      end
      S_F2: begin
        wr = '{we: 1'b1, addr: AW'(len_c - bta_pkg::CFG_W'(2)),
               data: -WW'(bta_pkg::TAG_WORDS)};
        state_nxt = S_F3;
      end
      S_F3: begin
        wr = '{we: 1'b1, addr: AW'(len_c - bta_pkg::CFG_W'(1)),
               data: -WW'(bta_pkg::TAG_WORDS)};
        heap_len_nxt  = len_c;
        formatted_nxt = 1'b1;
        out_valid_nxt = 1'b1;
        out_nxt       = '{handle_res: '0, status: bta_pkg::ST_FORMAT};
        state_nxt     = S_IDLE;
      end
      // allocate: list walk
      S_AINI: begin
        if (item_r.request_bytes == '0) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{handle_res: '0, status: bta_pkg::ST_ZERO};
          state_nxt     = S_IDLE;
        end else begin
          need_nxt  = need_c;
          best_nxt  = '1;
          pick_nxt  = '0;
          left_nxt  = 5'(bta_pkg::SCAN_FITS);
          steps_nxt = '0;
          p_nxt     = fh_r;
          state_nxt = S_ACHK;
        end
      end
      S_ACHK: begin
        raddr = p_r;
        if (p_r == '0 || steps_r == (AW+1)'(bta_pkg::HEAP_DEPTH)) begin
          state_nxt = S_ADONE;
        end else begin
          state_nxt = S_ASZ;
        end
      end
      S_ASZ: begin
        steps_nxt = steps_r + (AW+1)'(1);
        raddr     = p_r + AW'(1);
        state_nxt = S_ANX;
        if (rabs >= need_r) begin
          if (BW'(rabs) < best_r) begin
            best_nxt = BW'(rabs);
            pick_nxt = p_r;
          end
          left_nxt = left_r - 5'd1;
          if (left_r == 5'd1) begin
            state_nxt = S_ADONE;
          end
        end
      end
      S_ANX: begin
        p_nxt     = rdata[AW-1:0];
        state_nxt = S_ACHK;
      end
      S_ADONE: begin
        if (pick_r == '0) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{handle_res: '0, status: bta_pkg::ST_NOFIT};
          state_nxt     = S_IDLE;
        end else begin
          u_nxt     = pick_r;
          ret_nxt   = S_ASPL;
          state_nxt = S_U0;
        end
      end
      S_ASPL: begin
        alu_req = '{sub: 1'b1, a: best_r, b: BW'(need_r)};
        if (alu_sum >= BW'(bta_pkg::MIN_BLOCK)) begin
          split_nxt = 1'b1;
          tw_nxt    = need_r;
          mw_nxt    = alu_sum[WW-1:0];
          wr = '{we: 1'b1, addr: pick_r, data: WW'(SW'(0) - need_r)};
        end else begin
          split_nxt = 1'b0;
          tw_nxt    = SW'(best_r);
          wr = '{we: 1'b1, addr: pick_r, data: WW'(BW'(0) - best_r)};
        end
        state_nxt = S_AT2;
      end
      S_AT2: begin
        wr = '{we: 1'b1, addr: pick_r + AW'(tw_r) - AW'(1),
               data: WW'(SW'(0) - tw_r)};
        if (split_r) begin
          mi_nxt    = pick_r + AW'(need_r);
          ret_nxt   = S_AFIN;
          state_nxt = S_M0;
        end else begin
          state_nxt = S_AFIN;
        end
      end
      S_AFIN: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{handle_res: pick_r + AW'(1), status: bta_pkg::ST_ALLOC};
        state_nxt     = S_IDLE;
      end
      // release
      S_RCHK: begin
        raddr = item_r.handle - AW'(1);
        if (formatted_r && item_r.handle >= AW'(3) &&
            (14'(item_r.handle) + 14'd2) < 14'(heap_len_r)) begin
          state_nxt = S_RHD;
        end else begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{handle_res: '0, status: bta_pkg::ST_IGNORED};
          state_nxt     = S_IDLE;
        end
      end
      S_RHD: begin
        at_nxt = item_r.handle - AW'(1);
        sz_nxt = rabs;
        raddr  = item_r.handle - AW'(2);
        if (rdata[WW-1]) begin
          state_nxt = S_RLB;
        end else begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{handle_res: '0, status: bta_pkg::ST_IGNORED};
          state_nxt     = S_IDLE;
        end
      end
      S_RLB: begin
        alu_req   = '{sub: 1'b1, a: BW'(at_r), b: BW'(rabs)};
        lft_nxt   = alu_sum[AW-1:0];
        rgt_nxt   = at_r + sz_r[AW-1:0];
        raddr     = alu_sum[AW-1:0];
        state_nxt = S_RLW;
      end
      S_RLW: begin
        if (!rdata[WW-1] && rdata != '0) begin
          u_nxt     = lft_r;
          ret_nxt   = S_RLS;
          state_nxt = S_U0;
        end else begin
          state_nxt = S_RRC;
        end
      end
      S_RLS: begin
        raddr     = lft_r;
        state_nxt = S_RLA;
      end
      S_RLA: begin
        alu_req   = '{sub: 1'b0, a: BW'(sz_r), b: BW'(rabs)};
        sz_nxt    = SW'(alu_sum[WW-1:0]);
        at_nxt    = lft_r;
        state_nxt = S_RRC;
      end
      S_RRC: begin
        raddr     = rgt_r;
        state_nxt = S_RRW;
      end
      S_RRW: begin
        if (!rdata[WW-1] && rdata != '0) begin
          u_nxt     = rgt_r;
          ret_nxt   = S_RRS;
          state_nxt = S_U0;
        end else begin
          state_nxt = S_RMF;
        end
      end
      S_RRS: begin
        raddr     = rgt_r;
        state_nxt = S_RRA;
      end
      S_RRA: begin
        alu_req   = '{sub: 1'b0, a: BW'(sz_r), b: BW'(rabs)};
        sz_nxt    = SW'(alu_sum[WW-1:0]);
        state_nxt = S_RMF;
      end
      S_RMF: begin
        mi_nxt    = at_r;
        mw_nxt    = sz_r[WW-1:0];
        ret_nxt   = S_RFIN;
        state_nxt = S_M0;
      end
      S_RFIN: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{handle_res: '0, status: bta_pkg::ST_FREED};
        state_nxt     = S_IDLE;
      end
      // unlink block u from the free list
      S_U0: begin
        raddr     = u_r + AW'(2);
        state_nxt = S_U1;
      end
      S_U1: begin
        pv_nxt    = rdata[AW-1:0];
        raddr     = u_r + AW'(1);
        state_nxt = S_U2;
      end
      S_U2: begin
        nx_nxt = rdata[AW-1:0];
        if (pv_r == '0) begin
          fh_nxt = rdata[AW-1:0];
        end else begin
          wr = '{we: 1'b1, addr: pv_r + AW'(1), data: WW'(rdata[AW-1:0])};
        end
        state_nxt = S_U3;
      end
      S_U3: begin
        if (nx_r != '0) begin
          wr = '{we: 1'b1, addr: nx_r + AW'(2), data: WW'(pv_r)};
        end
        state_nxt = ret_r;
      end
      // tag block mi as free with mw words and push it on the list
      S_M0: begin
        wr        = '{we: 1'b1, addr: mi_r, data: mw_r};
        state_nxt = S_M1;
      end
      S_M1: begin
        wr        = '{we: 1'b1, addr: mi_r + AW'(mw_r) - AW'(1), data: mw_r};
        state_nxt = S_M2;
      end
      S_M2: begin
        wr        = '{we: 1'b1, addr: mi_r + AW'(1), data: WW'(fh_r)};
        state_nxt = S_M3;
      end
      S_M3: begin
        wr        = '{we: 1'b1, addr: mi_r + AW'(2), data: '0};
        state_nxt = S_M4;
      end
      S_M4: begin
        if (fh_r != '0) begin
          wr = '{we: 1'b1, addr: fh_r + AW'(2), data: WW'(mi_r)};
        end
        fh_nxt    = mi_r;
        state_nxt = ret_r;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      formatted_r <= 1'b0;
      fh_r        <= '0;
      heap_len_r  <= '0;
      cfg_r       <= bta_pkg::CFG_W'(bta_pkg::HEAP_DEPTH);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      formatted_r <= formatted_nxt;
      fh_r        <= fh_nxt;
      heap_len_r  <= heap_len_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ret_r   <= ret_nxt;
    item_r  <= item_nxt;
    out_r   <= out_nxt;
    p_r     <= p_nxt;
    pick_r  <= pick_nxt;
    at_r    <= at_nxt;
    lft_r   <= lft_nxt;
    rgt_r   <= rgt_nxt;
    u_r     <= u_nxt;
    pv_r    <= pv_nxt;
    nx_r    <= nx_nxt;
    mi_r    <= mi_nxt;
    mw_r    <= mw_nxt;
    sz_r    <= sz_nxt;
    need_r  <= need_nxt;
    tw_r    <= tw_nxt;
    best_r  <= best_nxt;
    split_r <= split_nxt;
    steps_r <= steps_nxt;
    left_r  <= left_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_beat_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while still working");

  a_cmd_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("command accepted without work or result");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !wr.we)
    else $error("store written while idle");

  a_alloc_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != bta_pkg::ST_ALLOC) |-> out_data.handle_res == '0)
    else $error("handle on a non-allocate result");

endmodule

// ----- sv/bta_ram.sv -----
// ----------------------------------------------------------------------------
// bta_ram
// Heap word store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bta_ram (
  input  logic                           clk,
  input  bta_pkg::mem_wr_t               wr,
  input  logic [bta_pkg::ADDR_W-1:0]     raddr,
  output logic [bta_pkg::WORD_W-1:0]     rdata
);

  logic [bta_pkg::WORD_W-1:0] mem [bta_pkg::HEAP_DEPTH];
  logic [bta_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/bta_alu.sv -----
// ----------------------------------------------------------------------------
// bta_alu
// Shared add/subtract unit for sizes and block addresses.
// ----------------------------------------------------------------------------
module bta_alu (
  input  bta_pkg::alu_req_t              req,
  output logic [bta_pkg::ALU_W-1:0]      sum
);

  always_comb begin
    if (req.sub) begin
      sum = req.a - req.b;
    end else begin
      sum = req.a + req.b;
    end
  end

endmodule

// ----- test/boundary_tag_heap_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_tb
// Self-checking bench: a scoreboard predicts the result of each command beat
// from its own copy of the heap and compares every result beat field by field.
// The heap size register is changed between phases, extremes included.
// ----------------------------------------------------------------------------
typedef struct {
  logic [15:0] mem [bta_pkg::HEAP_DEPTH];
  bit          known [bta_pkg::HEAP_DEPTH];
  int          head;
  bit          fmt;
  int          len;
  int          words_cfg;
} heap_state_t;

class heap_scoreboard;
  heap_state_t          s;
  bta_pkg::out_item_t   pending [$];
  int                   live [$];
  int                   errors;
  bit                   bad;

  function void clear();
    s.head = 0; s.fmt = 0; s.len = 0; s.words_cfg = 4096; errors = 0;
    foreach (s.known[i]) s.known[i] = 0;
  endfunction

  function int rd(int i);
    int a;
    a = i & (bta_pkg::HEAP_DEPTH - 1);
    if (!s.known[a]) bad = 1;
    return $signed(s.mem[a]);
  endfunction

  function int lnk(int i);
    return rd(i) & (bta_pkg::HEAP_DEPTH - 1);
  endfunction

  function int bsize(int i);
    int v;
    v = rd(i);
    return v < 0 ? -v : v;
  endfunction

  function void wr(int i, int v);
    int a;
    a = i & (bta_pkg::HEAP_DEPTH - 1);
    s.mem[a] = v[15:0];
    s.known[a] = 1;
  endfunction

  function void unlink_blk(int i);
    int pv, nx;
    pv = lnk(i + 2);
    nx = lnk(i + 1);
    if (pv == 0) s.head = nx;
    else wr(pv + 1, nx);
    if (nx != 0) wr(nx + 2, pv);
  endfunction

  function void mark_free(int i, int w);
    i = i & (bta_pkg::HEAP_DEPTH - 1);
    wr(i, w); wr(i + w - 1, w); wr(i + 1, s.head); wr(i + 2, 0);
    if (s.head != 0) wr(s.head + 2, i);
    s.head = i;
  endfunction

  function void mark_taken(int i, int w);
    wr(i, -w); wr(i + w - 1, -w);
  endfunction

  function bta_pkg::out_item_t apply(bta_pkg::in_item_t it);
    bta_pkg::out_item_t r;
    int need, best, pick, left, steps, p, sz, at, lft, rgt, h;
    r.handle_res = '0;
    r.status = bta_pkg::ST_IGNORED;
    h = it.handle;
    if (it.action == bta_pkg::ACT_FORMAT) begin
      sz = s.words_cfg;
      if (sz < 8) sz = 8;
      if (sz > bta_pkg::HEAP_DEPTH) sz = bta_pkg::HEAP_DEPTH;
      s.head = 0;
      mark_taken(0, bta_pkg::TAG_WORDS);
      mark_free(2, sz - 4);
      mark_taken(sz - 2, bta_pkg::TAG_WORDS);
      s.len = sz; s.fmt = 1;
      r.status = bta_pkg::ST_FORMAT;
    end else if (it.action == bta_pkg::ACT_ALLOC) begin
      if (it.request_bytes == 0) begin
        r.status = bta_pkg::ST_ZERO;
      end else begin
        need = (int'(it.request_bytes) + 3) / 4 + bta_pkg::TAG_WORDS;
        if (need < bta_pkg::MIN_BLOCK) need = bta_pkg::MIN_BLOCK;
        best = 32'h7FFFFFFF; pick = 0; left = bta_pkg::SCAN_FITS; steps = 0;
        p = s.head;
        while (p != 0 && steps < bta_pkg::HEAP_DEPTH) begin
          sz = bsize(p);
          steps++;
          if (sz >= need) begin
            if (sz < best) begin
              best = sz; pick = p;
            end
            left--;
            if (left == 0) break;
          end
          p = lnk(p + 1);
        end
        if (pick != 0) begin
          unlink_blk(pick);
          if (best - need >= bta_pkg::MIN_BLOCK) begin
            mark_taken(pick, need);
            mark_free(pick + need, best - need);
          end else begin
            mark_taken(pick, best);
          end
          r.handle_res = 12'(pick + 1);
          r.status = bta_pkg::ST_ALLOC;
        end else begin
          r.status = bta_pkg::ST_NOFIT;
        end
      end
    end else if (it.action == bta_pkg::ACT_RELEASE) begin
      if (s.fmt && h >= 3 && h + 2 < s.len) begin
        if (rd(h - 1) < 0) begin
          at = h - 1;
          sz = bsize(at);
          lft = (at - 1 - bsize(at - 1) + 1) & (bta_pkg::HEAP_DEPTH - 1);
          rgt = (at + sz) & (bta_pkg::HEAP_DEPTH - 1);
          if (rd(lft) > 0) begin
            unlink_blk(lft);
            at = lft;
            sz += bsize(lft);
          end
          if (rd(rgt) > 0) begin
            unlink_blk(rgt);
            sz += bsize(rgt);
          end
          mark_free(at, sz);
          r.status = bta_pkg::ST_FREED;
        end
      end
    end
    return r;
  endfunction

  // true when the command reads no heap word that was never written
  function bit safe(bta_pkg::in_item_t it);
    heap_state_t saved;
    saved = s;
    bad = 0;
    void'(apply(it));
    s = saved;
    return !bad;
  endfunction

  function void note_command(bta_pkg::in_item_t it);
    bta_pkg::out_item_t r;
    r = apply(it);
    pending.push_back(r);
    if (it.action == bta_pkg::ACT_FORMAT) live.delete();
    if (r.status == bta_pkg::ST_ALLOC) live.push_back(r.handle_res);
    if (r.status == bta_pkg::ST_FREED)
      foreach (live[i])
        if (live[i] == it.handle) begin
          live.delete(i);
          break;
        end
  endfunction

  function void check_result(bta_pkg::out_item_t got);
    bta_pkg::out_item_t e;
    if (pending.size() == 0) begin
      $display("%0t: result beat with nothing expected, got handle %0d status %0d",
               $time, got.handle_res, got.status);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.handle_res !== e.handle_res) begin
      $display("%0t: handle_res expected %0d actual %0d", $time, e.handle_res, got.handle_res);
      errors++;
    end
    if (got.status !== e.status) begin
      $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
      errors++;
    end
  endfunction
endclass

module boundary_tag_heap_allocator_tb;
  logic                        clk = 0;
  logic                        rst_n = 0;
  logic                        start = 0;
  logic                        busy;
  bta_pkg::in_item_t           in_data = '0;
  logic                        out_valid;
  bta_pkg::out_item_t          out_data;
  logic                        cfg_we = 0;
  logic [bta_pkg::CFG_W-1:0]   cfg_wdata = '0;
  heap_scoreboard              sb;
  int                          gap_mode;

  boundary_tag_heap_allocator uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk)
    if (rst_n && out_valid) sb.check_result(out_data);

  task automatic send(bta_pkg::in_item_t it);
    int gap;
    gap = gap_mode ? $urandom_range(0, 15) : 0;
    if (!sb.safe(it)) begin
      it = '0;
      it.action = bta_pkg::ACT_FORMAT;
    end
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    in_data <= it;
    start <= 1;
    do @(posedge clk); while (busy);
    sb.note_command(it);
  endtask

  task automatic cmd(logic [1:0] a, int b, int h);
    bta_pkg::in_item_t it;
    it.action = a;
    it.request_bytes = 15'(b);
    it.handle = 12'(h);
    send(it);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_words(int v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= bta_pkg::CFG_W'(v);
    @(posedge clk);
    cfg_we <= 0;
    sb.s.words_cfg = v & 16'h1FFF;
  endtask

  task automatic random_beat();
    bta_pkg::in_item_t it;
    int r, k;
    r = $urandom_range(0, 99);
    it.request_bytes = 15'($urandom_range(1, 64));
    it.handle = 12'($urandom);
    it.action = bta_pkg::ACT_ALLOC;
    if (r < 3) begin
      it.action = bta_pkg::ACT_FORMAT;
    end else if (r < 50) begin
      k = $urandom_range(0, 19);
      if (k < 3) it.request_bytes = 15'($urandom);
      else if (k < 6) it.request_bytes = 15'($urandom_range(1, 600));
      else if (k == 6) it.request_bytes = '0;
    end else if (r < 92 && sb.live.size() > 0) begin
      it.action = bta_pkg::ACT_RELEASE;
      it.handle = 12'(sb.live[$urandom_range(0, sb.live.size() - 1)]);
    end else begin
      it.action = 2'($urandom_range(0, 3));
      if (it.action == bta_pkg::ACT_FORMAT) it.action = bta_pkg::ACT_RELEASE;
    end
    send(it);
  endtask

  initial begin
    int sizes [9] = '{4096, 8, 7, 8191, 0, 100, 300, 4095, 64};
    sb = new();
    sb.clear();
    gap_mode = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // before any format
    cmd(bta_pkg::ACT_ALLOC, 5, 0);
    cmd(bta_pkg::ACT_RELEASE, 0, 10);
    cmd(2'd3, 15'h7FFF, 12'hFFF);
    cmd(bta_pkg::ACT_FORMAT, 0, 0);
    cmd(bta_pkg::ACT_ALLOC, 0, 0);
    cmd(bta_pkg::ACT_ALLOC, 1, 0);
    cmd(bta_pkg::ACT_ALLOC, 15'h7FFF, 0);
    cmd(bta_pkg::ACT_ALLOC, 16384, 0);
    cmd(bta_pkg::ACT_ALLOC, 8, 0);
    cmd(bta_pkg::ACT_ALLOC, 9, 0);
    cmd(bta_pkg::ACT_ALLOC, 12, 0);
    cmd(bta_pkg::ACT_RELEASE, 0, 0);
    cmd(bta_pkg::ACT_RELEASE, 0, 2);
    cmd(bta_pkg::ACT_RELEASE, 0, 4094);
    cmd(bta_pkg::ACT_RELEASE, 0, 4095);
    cmd(bta_pkg::ACT_RELEASE, 0, 8);
    cmd(bta_pkg::ACT_RELEASE, 0, 3);
    cmd(bta_pkg::ACT_RELEASE, 0, 3);
    cmd(bta_pkg::ACT_RELEASE, 0, 12);
    cmd(2'd3, 0, 0);
    cmd(bta_pkg::ACT_ALLOC, 4000 * 4, 0);
    foreach (sizes[p]) begin
      set_words(p == 8 ? $urandom_range(8, 200) : sizes[p]);
      gap_mode = $urandom_range(0, 2);
      cmd(bta_pkg::ACT_FORMAT, 0, 0);
      repeat (135) random_beat();
    end
    drain();
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #1000000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// ----- sim.f -----
sv/bta_pkg.sv
sv/bta_ram.sv
sv/bta_alu.sv
sv/boundary_tag_heap_allocator.sv
test/boundary_tag_heap_allocator_tb.sv
